/* rtl/scc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and search helpers of the sector cache tag engine.
// No dependencies; imported by every other file of the block.
package scc_pkg;

   localparam int ENTRIES     = 64;
   localparam int MAX_RESULTS = 64;
   localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ENTRY_W     = 6;
   localparam int SECTOR_W    = 32;
   localparam int KIND_W      = 2;
   localparam int CNT_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

   // two-level search tree: groups of eight, then a pick over the groups
   localparam int GROUP_W  = 8;
   localparam int LOC_W    = 3;
   localparam int GROUP_N  = ((ENTRIES + GROUP_W - 1) / GROUP_W < 2) ? 2 :
                             (ENTRIES + GROUP_W - 1) / GROUP_W;
   localparam int GSEL_W   = $clog2(GROUP_N);
   localparam int SRCH_W   = GSEL_W + LOC_W;
   localparam int PAD_W    = GROUP_N * GROUP_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_FLUSH = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic             any;
      logic [LOC_W-1:0] loc;
   } grp_hit_type;

   typedef grp_hit_type [GROUP_N-1:0] grp_vec_type;

   typedef struct packed {
      logic              any;
      logic [SRCH_W-1:0] idx;
   } srch_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;  // capture request payload
      logic fl_start;  // restart flush scan at entry zero
      logic commit;    // resolve access, update policy state
      logic fl_take;   // report the dirty entry under the scan index
      logic fl_skip;   // scan index to the next entry
      logic emit;      // load the result register
      logic fl_next;   // flush result sent, advance scan
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;  // result register can take a new transaction
      logic fl_more;   // a dirty entry at or above the scan index
      logic fl_dirty;  // entry under the scan index is dirty
      logic fl_last;   // pending flush result is the final one
   } sts_type;

   // lowest set bit within one group
   function automatic grp_hit_type grp_first(input logic [GROUP_W-1:0] v);
      grp_hit_type r;
      r.any = |v;
      r.loc = '0;
      for (int b = GROUP_W - 1; b >= 0; b--) begin
         if (v[b]) begin
            r.loc = LOC_W'(b);
         end
      end
      return r;
   endfunction

   // lowest group with a hit, joined with its local index
   function automatic srch_type pick_first(input grp_vec_type g);
      srch_type r;
      r.any = 1'b0;
      r.idx = '0;
      for (int k = GROUP_N - 1; k >= 0; k--) begin
         if (g[k].any) begin
            r.any = 1'b1;
            r.idx = {GSEL_W'(k), g[k].loc};
         end
      end
      return r;
   endfunction

endpackage

/* rtl/scc_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the sector cache tag engine: access and flush flows.
// Depends on scc_pkg (command/status structs, request kinds).
module scc_ctrl
   import scc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [KIND_W-1:0]   req_kind,
   output logic                req_ready,
   input  sts_type             sts,
   output cmd_type             cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_PICK,
      S_EMIT,
      S_FSCAN,
      S_FEMIT
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.load_req = accept;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (kind_type'(req_kind))
                  KIND_READ, KIND_WRITE: state_in = S_LOOK;
                  KIND_FLUSH: begin
                     cmd.fl_start = 1'b1;
                     state_in     = S_FSCAN;
                  end
                  default: state_in = S_IDLE;  // unused kind is dropped
               endcase
            end
         end
         S_LOOK: state_in = S_PICK;
         S_PICK: begin
            cmd.commit = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FSCAN: begin
            if (!sts.fl_more) begin
               state_in = S_IDLE;
            end else if (sts.fl_dirty) begin
               cmd.fl_take = 1'b1;
               state_in    = S_FEMIT;
            end else begin
               cmd.fl_skip = 1'b1;
            end
         end
         S_FEMIT: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.fl_next = 1'b1;
               state_in    = sts.fl_last ? S_IDLE : S_FSCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/scc_dp.sv */
`timescale 1ns / 1ps
// Datapath of the sector cache tag engine: tag lanes, policy bits, clock hand,
// search tree, tag RAM for write-back reads and the result register. Uses scc_pkg.
module scc_dp
   import scc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SECTOR_W-1:0] req_sector,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_hit,
   output logic [ENTRY_W-1:0]  rsp_entry,
   output logic                rsp_writeback,
   output logic [SECTOR_W-1:0] rsp_writeback_sector,
   output logic                rsp_fill,
   output logic                rsp_last
);

   // captured request
   logic [SECTOR_W-1:0] sector_ff;
   logic                wr_ff;

   // policy state
   logic [SECTOR_W-1:0] tag_ff [ENTRIES];   // compare lanes
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [ENTRIES-1:0]  dirty_ff, dirty_in;
   logic [ENTRIES-1:0]  ref_ff, ref_in;
   idx_type             hand_ff, hand_in;

   // copy of the tags for single-address reads
   logic [SECTOR_W-1:0] tag_mem [ENTRIES];
   logic [SECTOR_W-1:0] mem_rd_ff;
   logic                mem_re, mem_we;
   idx_type             mem_ra;

   // search tree
   logic [ENTRIES-1:0]  match_vec, hi_vec, all_vec;
   logic [PAD_W-1:0]    match_pad, hi_pad, all_pad;
   grp_vec_type         match_grp_in, hi_grp_in, all_grp_in;
   grp_vec_type         match_grp_ff, hi_grp_ff, all_grp_ff;
   srch_type            match_pick, hi_pick, all_pick;

   // access resolution
   logic                hit;
   idx_type             hit_idx, vic;
   logic [ENTRIES-1:0]  ge_hand, lt_vic, clr;
   logic [ENTRIES-1:0]  ge_idx, gt_idx;

   // flush scan and pending result
   idx_type             idx_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                res_hit_ff, res_wb_ff, res_fill_ff, res_last_ff;
   idx_type             res_ent_ff;
   logic                fl_last;

   // ---------------- stage one: lane compares and group encode ----------
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i] = valid_ff[i] && (tag_ff[i] == sector_ff);
         ge_hand[i]   = (IDX_W'(i) >= hand_ff);
         hi_vec[i]    = !ref_ff[i] && ge_hand[i];
         all_vec[i]   = !ref_ff[i];
      end
      match_pad = PAD_W'(match_vec);
      hi_pad    = PAD_W'(hi_vec);
      all_pad   = PAD_W'(all_vec);
      for (int g = 0; g < GROUP_N; g++) begin
         match_grp_in[g] = grp_first(match_pad[g*GROUP_W +: GROUP_W]);
         hi_grp_in[g]    = grp_first(hi_pad[g*GROUP_W +: GROUP_W]);
         all_grp_in[g]   = grp_first(all_pad[g*GROUP_W +: GROUP_W]);
      end
   end

   always_ff @(posedge clock) begin
      match_grp_ff <= match_grp_in;
      hi_grp_ff    <= hi_grp_in;
      all_grp_ff   <= all_grp_in;
   end

   // ---------------- stage two: pick hit entry and clock victim ---------
   always_comb begin
      match_pick = pick_first(match_grp_ff);
      hi_pick    = pick_first(hi_grp_ff);
      all_pick   = pick_first(all_grp_ff);
      hit        = match_pick.any;
      hit_idx    = IDX_W'(match_pick.idx);
      if (hi_pick.any) begin
         vic = IDX_W'(hi_pick.idx);
      end else if (all_pick.any) begin
         vic = IDX_W'(all_pick.idx);
      end else begin
         vic = hand_ff;  // every bit was set: full sweep lands on the hand
      end
      for (int i = 0; i < ENTRIES; i++) begin
         lt_vic[i] = (IDX_W'(i) < vic);
         ge_idx[i] = (IDX_W'(i) >= idx_ff);
         gt_idx[i] = (IDX_W'(i) > idx_ff);
      end
      // referenced bits the sweep passes over
      if (!all_pick.any) begin
         clr = '1;
      end else if (!hi_pick.any) begin
         clr = ge_hand | lt_vic;   // sweep wrapped past the top entry
      end else begin
         clr = ge_hand & lt_vic;
      end
   end

   // ---------------- policy state update --------------------------------
   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      ref_in   = ref_ff;
      hand_in  = hand_ff;
      if (cmd.commit) begin
         if (hit) begin
            ref_in[hit_idx] = 1'b1;
            if (wr_ff) begin
               dirty_in[hit_idx] = 1'b1;
            end
         end else begin
            ref_in        = ref_ff & ~clr;
            ref_in[vic]   = 1'b1;
            valid_in[vic] = 1'b1;
            dirty_in[vic] = wr_ff;
            hand_in       = (vic == idx_type'(ENTRIES - 1)) ? '0 : vic + 1'b1;
         end
      end
      if (cmd.fl_take) begin
         dirty_in[idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         ref_ff   <= '0;
         hand_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         ref_ff   <= ref_in;
         hand_ff  <= hand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         sector_ff <= req_sector;
         wr_ff     <= (kind_type'(req_kind) == KIND_WRITE);
      end
      if (cmd.commit && !hit) begin
         tag_ff[vic] <= sector_ff;
      end
   end

   // ---------------- tag RAM: old tag of victim or flushed entry --------
   assign mem_we = cmd.commit && !hit;
   assign mem_re = cmd.commit || cmd.fl_take;
   assign mem_ra = cmd.commit ? vic : idx_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[vic] <= sector_ff;
      end
      if (mem_re) begin
         mem_rd_ff <= tag_mem[mem_ra];  // read-first: old tag on refill
      end
   end

   // ---------------- flush scan -----------------------------------------
   assign fl_last = !(|(dirty_ff & gt_idx)) || (cnt_ff == CNT_W'(MAX_RESULTS - 1));

   always_ff @(posedge clock) begin
      if (cmd.fl_start) begin
         idx_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.fl_skip || cmd.fl_next) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.fl_next) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // ---------------- pending result -------------------------------------
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_hit_ff  <= hit;
         res_ent_ff  <= hit ? hit_idx : vic;
         res_wb_ff   <= !hit && dirty_ff[vic];
         res_fill_ff <= !hit;
         res_last_ff <= 1'b1;
      end else if (cmd.fl_take) begin
         res_hit_ff  <= 1'b0;
         res_ent_ff  <= idx_ff;
         res_wb_ff   <= 1'b1;
         res_fill_ff <= 1'b0;
         res_last_ff <= fl_last;
      end
   end

   // ---------------- result register ------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_hit              <= res_hit_ff;
         rsp_entry            <= ENTRY_W'(res_ent_ff);
         rsp_writeback        <= res_wb_ff;
         rsp_writeback_sector <= res_wb_ff ? mem_rd_ff : '0;
         rsp_fill             <= res_fill_ff;
         rsp_last             <= res_last_ff;
      end
   end

   assign sts.out_free = !rsp_valid || rsp_ready;
   assign sts.fl_more  = |(dirty_ff & ge_idx);
   assign sts.fl_dirty = dirty_ff[idx_ff];
   assign sts.fl_last  = res_last_ff;

endmodule

/* rtl/sector_cache_clock_replacement.sv */
`timescale 1ns / 1ps
// Top level of the sector cache tag engine (fully associative, write-back,
// clock replacement). Depends on scc_pkg, scc_ctrl and scc_dp.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   request | req_valid/req_ready, req_kind, req_sector    | in
//   result  | rsp_valid/rsp_ready, rsp_hit, rsp_entry,     | out
//           | rsp_writeback, rsp_writeback_sector,         |
//           | rsp_fill, rsp_last                           |
//
// Read/write: one transaction at a time, in order: accept, lane compare and group encode,
//   pick of hit entry / clock victim with state update and tag RAM read, then
//   the result register load, which waits while an earlier result is still held.
// Flush: clean entries are skipped in turn; each dirty entry reported takes a tag RAM
//   read, then a result load. The scan stops as soon as no dirty entry remains at or
//   above the scan index. Nothing dirty gives no result transaction.
// Unused kind 3 is accepted and dropped; the engine stays ready.
// Reset clears valid, dirty, referenced bits and the hand at once; tags are
//   never read before written, so there is no clearing pass.
// A stalled result stays in the output register; the engine waits only when
//   a second result is ready while the first is still held.
module sector_cache_clock_replacement
   import scc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SECTOR_W-1:0] req_sector,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_hit,
   output logic [ENTRY_W-1:0]  rsp_entry,
   output logic                rsp_writeback,
   output logic [SECTOR_W-1:0] rsp_writeback_sector,
   output logic                rsp_fill,
   output logic                rsp_last
);

   cmd_type cmd;
   sts_type sts;

   // sequencer: picks access or flush flow, issues commands
   scc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tag lanes, policy bits, search tree, tag RAM, result register
   scc_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_kind             (req_kind),
      .req_sector           (req_sector),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_hit              (rsp_hit),
      .rsp_entry            (rsp_entry),
      .rsp_writeback        (rsp_writeback),
      .rsp_writeback_sector (rsp_writeback_sector),
      .rsp_fill             (rsp_fill),
      .rsp_last             (rsp_last)
   );

endmodule

/* rtl/scc_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the sector cache tag engine, bound to the top level.
// Depends on scc_pkg and sector_cache_clock_replacement.
module scc_checker
   import scc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_hit,
   input logic [ENTRY_W-1:0]  rsp_entry,
   input logic                rsp_writeback,
   input logic [SECTOR_W-1:0] rsp_writeback_sector,
   input logic                rsp_fill,
   input logic                rsp_last
);

   // result register is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry) &&
                                 $stable(rsp_writeback_sector) && $stable(rsp_last))
      else $error("stalled result changed");

   // a hit neither fills nor writes back
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_fill && !rsp_writeback &&
                               rsp_writeback_sector == '0 && rsp_last)
      else $error("hit result with fill or write-back");

   // a miss is a single, final transaction
   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fill |-> !rsp_hit && rsp_last)
      else $error("miss result not final");

   // flush results always write back; sector is zero without write-back
   a_flush_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_writeback |-> rsp_writeback_sector == '0 &&
                                      (rsp_hit || rsp_fill))
      else $error("write-back flag and sector disagree");

endmodule

bind sector_cache_clock_replacement scc_checker u_scc_checker (.*);

/* bench/scc_outcome_checker.sv */
`timescale 1ns / 1ps
// Result checker for the sector cache tag engine: keeps its own tags, policy bits
// and clock hand, predicts each result and compares it. Depends on scc_pkg.
module scc_outcome_checker
   import scc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_hit,
   input  logic [ENTRY_W-1:0]  rsp_entry,
   input  logic                rsp_writeback,
   input  logic [SECTOR_W-1:0] rsp_writeback_sector,
   input  logic                rsp_fill,
   input  logic                rsp_last,
   output int                  mismatches,
   output int                  outstanding
);

   localparam int PRINT_CAP = 40;

   typedef struct {
      logic                hit;
      logic [ENTRY_W-1:0]  entry;
      logic                writeback;
      logic [SECTOR_W-1:0] wb_sector;
      logic                fill;
      logic                last;
   } outcome_type;

   outcome_type         pending_outcomes[$];
   logic [SECTOR_W-1:0] sector_tag [ENTRIES];
   logic [ENTRIES-1:0]  line_valid;
   logic [ENTRIES-1:0]  line_dirty;
   logic [ENTRIES-1:0]  line_ref;
   int                  hand_pos;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // read or write: lowest matching valid line, else second-chance victim
   task automatic apply_access(input logic is_write, input logic [SECTOR_W-1:0] sector);
      outcome_type o;
      int          found;
      int          h;
      found       = -1;
      o.hit       = 1'b0;
      o.entry     = '0;
      o.writeback = 1'b0;
      o.wb_sector = '0;
      o.fill      = 1'b0;
      o.last      = 1'b1;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (line_valid[i] && sector_tag[i] == sector) begin
            found = i;
         end
      end
      if (found >= 0) begin
         line_ref[found] = 1'b1;
         if (is_write) begin
            line_dirty[found] = 1'b1;
         end
         o.hit   = 1'b1;
         o.entry = ENTRY_W'(found);
      end else begin
         h = hand_pos;
         for (int n = 0; n <= ENTRIES && line_ref[h]; n++) begin
            line_ref[h] = 1'b0;
            h = (h + 1) % ENTRIES;
         end
         if (line_dirty[h]) begin
            o.writeback = 1'b1;
            o.wb_sector = sector_tag[h];
         end
         hand_pos      = (h + 1) % ENTRIES;
         sector_tag[h] = sector;
         line_valid[h] = 1'b1;
         line_dirty[h] = is_write;
         line_ref[h]   = 1'b1;
         o.entry       = ENTRY_W'(h);
         o.fill        = 1'b1;
      end
      pending_outcomes.push_back(o);
   endtask

   // flush: lowest dirty lines in index order, capped at MAX_RESULTS
   task automatic apply_flush();
      outcome_type o;
      int          reported;
      int          final_idx;
      reported  = 0;
      final_idx = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (line_dirty[i] && reported < MAX_RESULTS) begin
            final_idx = i;
            reported++;
         end
      end
      for (int i = 0; i <= final_idx; i++) begin
         if (line_dirty[i]) begin
            o.hit         = 1'b0;
            o.entry       = ENTRY_W'(i);
            o.writeback   = 1'b1;
            o.wb_sector   = sector_tag[i];
            o.fill        = 1'b0;
            o.last        = (i == final_idx);
            line_dirty[i] = 1'b0;
            pending_outcomes.push_back(o);
         end
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         pending_outcomes.delete();
         line_valid = '0;
         line_dirty = '0;
         line_ref   = '0;
         hand_pos   = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            sector_tag[i] = '0;
         end
      end else begin
         // predict first: the queue front is always the oldest transaction
         if (req_valid && req_ready) begin
            case (kind_type'(req_kind))
               KIND_READ:  apply_access(1'b0, req_sector);
               KIND_WRITE: apply_access(1'b1, req_sector);
               KIND_FLUSH: apply_flush();
               default:    ;  // unused kind: no result, no state change
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               if (mismatches < PRINT_CAP) begin
                  $display(
                     "%0t: expected nothing, got hit=%0b ent=%0d wb=%0b sec=%h fill=%0b last=%0b",
                     $time, rsp_hit, rsp_entry, rsp_writeback, rsp_writeback_sector,
                     rsp_fill, rsp_last);
               end
               mismatches++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_hit !== want.hit || rsp_entry !== want.entry ||
                   rsp_writeback !== want.writeback ||
                   rsp_writeback_sector !== want.wb_sector ||
                   rsp_fill !== want.fill || rsp_last !== want.last) begin
                  if (mismatches < PRINT_CAP) begin
                     $display("%0t: expected hit=%0b ent=%0d wb=%0b sec=%h fill=%0b last=%0b",
                              $time, want.hit, want.entry, want.writeback, want.wb_sector,
                              want.fill, want.last);
                     $display("%0t:   actual hit=%0b ent=%0d wb=%0b sec=%h fill=%0b last=%0b",
                              $time, rsp_hit, rsp_entry, rsp_writeback, rsp_writeback_sector,
                              rsp_fill, rsp_last);
                  end
                  mismatches++;
               end
            end
         end
      end
      outstanding = pending_outcomes.size();
   end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the sector cache tag engine: clock, reset, request stimulus,
// result-side backpressure and the verdict. Depends on scc_pkg, scc_outcome_checker.
module tb_top;
   import scc_pkg::*;

   // Longest quiet stretch comes from a flush stepping over clean entries while the
   // receiver stalls; STALL_LIMIT leaves a wide margin over that.
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOT_SECTORS  = 40;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_valid  = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind   = KIND_READ;
   logic [SECTOR_W-1:0] req_sector = '0;
   logic                rsp_valid;
   logic                rsp_ready  = 1'b0;
   logic                rsp_hit;
   logic [ENTRY_W-1:0]  rsp_entry;
   logic                rsp_writeback;
   logic [SECTOR_W-1:0] rsp_writeback_sector;
   logic                rsp_fill;
   logic                rsp_last;

   int                  mismatches;
   int                  outstanding;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  quiet_cycles  = 0;
   logic [SECTOR_W-1:0] hot_sectors [HOT_SECTORS];

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sector_cache_clock_replacement i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_sector           (req_sector),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_hit              (rsp_hit),
      .rsp_entry            (rsp_entry),
      .rsp_writeback        (rsp_writeback),
      .rsp_writeback_sector (rsp_writeback_sector),
      .rsp_fill             (rsp_fill),
      .rsp_last             (rsp_last)
   );

   scc_outcome_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_sector           (req_sector),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_hit              (rsp_hit),
      .rsp_entry            (rsp_entry),
      .rsp_writeback        (rsp_writeback),
      .rsp_writeback_sector (rsp_writeback_sector),
      .rsp_fill             (rsp_fill),
      .rsp_last             (rsp_last),
      .mismatches           (mismatches),
      .outstanding          (outstanding)
   );

   // Receiver backpressure: a fresh coin every cycle, odds set per phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: any accepted transaction on either channel restarts the count.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // One request transaction. Returns at the edge where it was accepted with
   // valid still high, so back-to-back requests never drop valid for a cycle.
   // A sender gap lowers valid at that edge and raises it again after a random idle gap.
   task automatic send_request(input kind_type kind, input logic [SECTOR_W-1:0] sector);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_sector <= sector;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Mixed traffic: mostly a small hot set (lots of hits, some dirty), plus cold
   // sectors that force evictions, flushes and a few dropped kind-3 requests.
   // Dropped requests do not count toward the total.
   task automatic run_traffic(input int count);
      int                  done_items;
      int                  pick;
      logic [SECTOR_W-1:0] hot;
      done_items = 0;
      while (done_items < count) begin
         pick = $urandom_range(99);
         hot  = hot_sectors[$urandom_range(HOT_SECTORS - 1)];
         if (pick < 4) begin
            send_request(KIND_NONE, $urandom);
         end else begin
            if (pick < 10) begin
               send_request(KIND_FLUSH, $urandom);
            end else if (pick < 20) begin
               send_request($urandom_range(1) ? KIND_WRITE : KIND_READ, $urandom);
            end else begin
               send_request($urandom_range(1) ? KIND_WRITE : KIND_READ, hot);
            end
            done_items++;
         end
      end
   endtask

   // Write enough fresh sectors to dirty every entry (the hand walks round once
   // all referenced bits are clear), then flush: 64 results, last on the 64th.
   // Victims along the way are often dirty, so write-backs show up here too.
   task automatic dirty_sweep();
      for (int n = 0; n < ENTRIES + 6; n++) begin
         send_request(KIND_WRITE, $urandom);
      end
      send_request(KIND_FLUSH, '0);
   endtask

   task automatic traffic_phase(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      run_traffic(30);
      dirty_sweep();
      run_traffic(30);
   endtask

   initial begin
      for (int i = 0; i < HOT_SECTORS; i++) begin
         hot_sectors[i] = $urandom;
      end
      send_idle_pct = 12;
      recv_idle_pct = 58;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes of the sector, hit and miss for both access kinds,
      // a flush with dirty lines, a flush with nothing dirty, kind 3 dropped.
      send_request(KIND_READ,  32'h0000_0000);   // miss into entry 0
      send_request(KIND_WRITE, 32'h0000_0000);   // hit, marks dirty
      send_request(KIND_WRITE, 32'hFFFF_FFFF);   // miss, dirty fill
      send_request(KIND_READ,  32'hFFFF_FFFF);   // hit
      send_request(KIND_READ,  32'hAAAA_AAAA);   // clean miss
      send_request(KIND_WRITE, 32'h5555_5555);   // dirty miss
      send_request(KIND_NONE,  32'hFFFF_FFFF);   // dropped, no state change
      send_request(KIND_FLUSH, 32'hFFFF_FFFF);   // three dirty lines, sector ignored
      send_request(KIND_FLUSH, 32'h0000_0000);   // nothing dirty, no result
      send_request(KIND_WRITE, 32'h0000_0001);
      send_request(KIND_READ,  32'h0000_0000);   // still cached after flush
      send_request(KIND_WRITE, 32'h8000_0000);
      send_request(KIND_READ,  32'h7FFF_FFFF);
      send_request(KIND_WRITE, 32'hAAAA_AAAA);   // hit on a clean line, now dirty
      send_request(KIND_FLUSH, 32'h0000_0000);

      // Random: sender light / receiver heavy, then swapped, then no idling.
      traffic_phase(12, 58);
      traffic_phase(58, 12);
      traffic_phase(0, 0);

      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/scc_pkg.sv
rtl/scc_ctrl.sv
rtl/scc_dp.sv
rtl/sector_cache_clock_replacement.sv
rtl/scc_checker.sv
bench/scc_outcome_checker.sv
bench/tb_top.sv
